// File: hdl/rmc_sentence_field_extractor_unit_defines.svh
// Assertion macros shared by the sentence field extractor RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef RMC_SENTENCE_FIELD_EXTRACTOR_UNIT_DEFINES_SVH
`define RMC_SENTENCE_FIELD_EXTRACTOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define RMC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define RMC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/rmc_pkg.sv
// Shared types, constants and the field lookup for the sentence field extractor.
// No dependencies; imported by the parser core and the top level.
`default_nettype none

package rmc_pkg;

    // Character constants of the sentence format.
    localparam logic [7:0]  C_SEPARATOR    = 8'h2C;
    localparam logic [31:0] C_TAG_HEAD     = 32'h4750524D;
    localparam logic [7:0]  C_TAG_TAIL     = 8'h43;
    localparam logic [3:0]  C_LAST_ORDINAL = 4'd9;
    localparam logic [2:0]  C_TOKEN_SAT    = 3'd5;

    // Field numbers carried on the result channel.
    localparam logic [2:0] FIELD_TIME    = 3'd0;
    localparam logic [2:0] FIELD_LAT     = 3'd1;
    localparam logic [2:0] FIELD_LAT_DIR = 3'd2;
    localparam logic [2:0] FIELD_LON     = 3'd3;
    localparam logic [2:0] FIELD_LON_DIR = 3'd4;
    localparam logic [2:0] FIELD_SPEED   = 3'd5;
    localparam logic [2:0] FIELD_DATE    = 3'd6;

    // One result item plus its presence flag.
    typedef struct packed {
        logic       valid;
        logic [2:0] field_id;
        logic [7:0] field_byte;
        logic       byte_valid;
        logic       field_end;
    } t_result;

    // Field selection for one token ordinal.
    typedef struct packed {
        logic       hit;
        logic [2:0] id;
    } t_field_sel;

    // Maps a token ordinal after the tag token to its field, if it is captured.
    function automatic t_field_sel field_of(input logic [3:0] ordinal);
        t_field_sel sel;
        sel.hit = 1'b1;
        sel.id  = FIELD_TIME;
        case (ordinal)
            4'd1: sel.id = FIELD_TIME;
            4'd3: sel.id = FIELD_LAT;
            4'd4: sel.id = FIELD_LAT_DIR;
            4'd5: sel.id = FIELD_LON;
            4'd6: sel.id = FIELD_LON_DIR;
            4'd7: sel.id = FIELD_SPEED;
            4'd9: sel.id = FIELD_DATE;
            default: sel.hit = 1'b0;
        endcase
        return sel;
    endfunction

endpackage

`default_nettype wire

// File: hdl/rmc_token_parser.sv
// Tokenizer and field selector: holds the parse state and forms at most one result per transfer.
// Depends on rmc_pkg and the assertion macro header.
`default_nettype none
`include "rmc_sentence_field_extractor_unit_defines.svh"

module rmc_token_parser
    import rmc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_accept,
    input  wire logic [7:0] i_char_byte,
    input  wire logic    i_last_of_buffer,
    output t_result      o_result
);

    // Parse mode codes; the unused code behaves as finished.
    localparam logic [1:0] MODE_SEARCH  = 2'd0;
    localparam logic [1:0] MODE_CAPTURE = 2'd1;
    localparam logic [1:0] MODE_DONE    = 2'd2;

    logic [1:0]  r_mode,    n_mode;
    logic [31:0] r_recent,  n_recent;
    logic [2:0]  r_count,   n_count;
    logic        r_tag,     n_tag;
    logic [3:0]  r_ordinal, n_ordinal;

    t_field_sel  w_sel;
    t_result     w_result;
    logic        w_is_sep;

    assign w_sel    = field_of(r_ordinal);
    assign w_is_sep = (i_char_byte == C_SEPARATOR);

    // Next state and result for the character in transfer.
    always_comb begin
        n_mode    = r_mode;
        n_recent  = r_recent;
        n_count   = r_count;
        n_tag     = r_tag;
        n_ordinal = r_ordinal;
        w_result  = '0;

        if (w_is_sep) begin
            // A separator closes a non-empty token; runs of commas do nothing.
            if (r_count != 3'd0) begin
                if (r_mode == MODE_SEARCH) begin
                    if (r_tag) begin
                        n_mode    = MODE_CAPTURE;
                        n_ordinal = 4'd1;
                    end
                end else if (r_mode == MODE_CAPTURE) begin
                    if (w_sel.hit) begin
                        w_result.valid     = 1'b1;
                        w_result.field_id  = w_sel.id;
                        w_result.field_end = 1'b1;
                    end
                    if (r_ordinal >= C_LAST_ORDINAL) begin
                        n_mode = MODE_DONE;
                    end else begin
                        n_ordinal = r_ordinal + 4'd1;
                    end
                end
            end
            n_recent = '0;
            n_count  = '0;
            n_tag    = 1'b0;
        end else begin
            // An ordinary character: forward it if its token is captured.
            if (r_mode == MODE_CAPTURE && w_sel.hit) begin
                w_result.valid      = 1'b1;
                w_result.field_id   = w_sel.id;
                w_result.field_byte = i_char_byte;
                w_result.byte_valid = 1'b1;
                w_result.field_end  = i_last_of_buffer;
            end
            if (r_count < C_TOKEN_SAT) begin
                n_count = r_count + 3'd1;
            end
            // Tag match: four held characters plus this one spell the tag.
            if (r_mode == MODE_SEARCH && n_count >= C_TOKEN_SAT &&
                r_recent == C_TAG_HEAD && i_char_byte == C_TAG_TAIL) begin
                n_tag = 1'b1;
            end
            n_recent = {r_recent[23:0], i_char_byte};
        end

        // The final character of a buffer returns the parser to searching.
        if (i_last_of_buffer) begin
            n_mode    = MODE_SEARCH;
            n_ordinal = '0;
            n_recent  = '0;
            n_count   = '0;
            n_tag     = 1'b0;
        end

        if (!i_accept) begin
            w_result.valid = 1'b0;
        end
    end

    assign o_result = w_result;

    // Parse state registers, updated on each input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_SEARCH;
            r_recent  <= '0;
            r_count   <= '0;
            r_tag     <= 1'b0;
            r_ordinal <= '0;
        end else if (i_accept) begin
            r_mode    <= n_mode;
            r_recent  <= n_recent;
            r_count   <= n_count;
            r_tag     <= n_tag;
            r_ordinal <= n_ordinal;
        end
    end

    // Consistency of the parse state.
    `RMC_ASSERT_SAME(a_capture_ordinal, r_mode == MODE_CAPTURE,
        r_ordinal >= 4'd1 && r_ordinal <= C_LAST_ORDINAL, "capture ordinal out of range")
    `RMC_ASSERT_SAME(a_tag_count, r_tag, r_count == C_TOKEN_SAT && r_mode == MODE_SEARCH,
        "tag flag set on a short token or outside search")
    `RMC_ASSERT_SAME(a_result_mode, o_result.valid, r_mode == MODE_CAPTURE && i_accept,
        "result formed outside capture")

endmodule

`default_nettype wire

// File: hdl/rmc_sentence_field_extractor_unit.sv
// Sentence field extractor: top level with input/output handshakes and a result skid stage.
// Depends on rmc_pkg, rmc_token_parser and the assertion macro header.
//
// Usage:
//   Characters of a sentence buffer enter on the input channel (i_in_valid /
//   o_in_ready), one per transfer, with i_last_of_buffer on the final one.
//   Captured field characters and end-of-field marks leave on the result
//   channel (o_out_valid / i_out_ready); a character produces zero or one
//   result.
//   Throughput: one character per cycle while the skid is empty. The parse state updates in the
//   cycle of the input transfer, so a new character may follow at once.
//   A result is registered into r_out, or into r_skid while output stalls.
//   Stall: an output register and a one-entry skid register hold results.
//   Input stays ready while the skid is empty, so characters keep being taken
//   after the receiver stops until one more result lands in the skid;
//   o_in_ready falls only when both are full.
//   Reset (synchronous, active low): parser returns to searching for the
//   tag token and both result registers are emptied.
`default_nettype none
`include "rmc_sentence_field_extractor_unit_defines.svh"

module rmc_sentence_field_extractor_unit
    import rmc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_char_byte,
    input  wire logic       i_last_of_buffer,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [2:0]      o_field_id,
    output logic [7:0]      o_field_byte,
    output logic            o_byte_valid,
    output logic            o_field_end
);

    logic     w_accept;
    logic     w_drain;
    t_result  w_new;
    t_result  r_out;
    t_result  r_skid;

    assign o_in_ready = !r_skid.valid;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_drain    = !r_out.valid || i_out_ready;

    // Parser core.
    rmc_token_parser u_parser (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (w_accept),
        .i_char_byte      (i_char_byte),
        .i_last_of_buffer (i_last_of_buffer),
        .o_result         (w_new)
    );

    // Output register with skid: the skid catches a result while output stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid  <= 1'b0;
            r_skid.valid <= 1'b0;
        end else if (w_drain) begin
            if (r_skid.valid) begin
                r_out  <= r_skid;
                r_skid <= w_new;
            end else begin
                r_out        <= w_new;
                r_skid.valid <= 1'b0;
            end
        end else if (w_new.valid) begin
            r_skid <= w_new;
        end
    end

    assign o_out_valid  = r_out.valid;
    assign o_field_id   = r_out.field_id;
    assign o_field_byte = r_out.field_byte;
    assign o_byte_valid = r_out.byte_valid;
    assign o_field_end  = r_out.field_end;

    // Skid stage ordering checks.
    `RMC_ASSERT_SAME(a_skid_behind_out, r_skid.valid, r_out.valid,
        "skid holds a result while output is empty")
    `RMC_ASSERT_NEXT(a_skid_holds, r_skid.valid && !i_out_ready, r_skid.valid,
        "skid result lost during stall")
    `RMC_ASSERT_NEXT(a_stall_to_skid, w_new.valid && !w_drain, r_skid.valid,
        "result during stall not caught by skid")

endmodule

`default_nettype wire
